FILE: src/rtc_pkg.sv
// Shared types, codes and reset values for the reaction timer controller.
package rtc_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned DelayWidth = 24;
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned LedOutW    = 4;
  localparam int unsigned DefLedCount = 4;

  localparam logic [CfgWidth-1:0] IdlePeriodReset   = 16'd400;
  localparam logic [CfgWidth-1:0] TicksPerSecReset  = 16'd4000;
  localparam logic [CfgWidth-1:0] ResponseLimReset  = 16'd40000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_IDLE_PERIOD    = 2'd0;
  localparam logic [1:0] REG_TICKS_PER_SEC  = 2'd1;
  localparam logic [1:0] REG_RESPONSE_LIMIT = 2'd2;

  // Item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ARMED   = 3'd1,
    PH_WAIT    = 3'd2,
    PH_RUN     = 3'd3,
    PH_TIMEOUT = 3'd4,
    PH_ERROR   = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [CfgWidth-1:0] idle_period;
    logic [CfgWidth-1:0] ticks_per_second;
    logic [CfgWidth-1:0] response_limit;
  } cfg_t;

  typedef struct packed {
    logic [LedOutW-1:0]   led_value;
    logic                 led_written;
    logic [2:0]           phase_code;
    logic [TickWidth-1:0] response_ticks;
  } result_t;

endpackage

FILE: src/rtc_cfg_regs.sv
// Configuration register file of the reaction timer controller.
module rtc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rtc_pkg::CfgWidth-1:0] cfg_data,
  output rtc_pkg::cfg_t                cfg
);
  import rtc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_period      <= IdlePeriodReset;
      cfg.ticks_per_second <= TicksPerSecReset;
      cfg.response_limit   <= ResponseLimReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IDLE_PERIOD:    cfg.idle_period      <= cfg_data;
        REG_TICKS_PER_SEC:  cfg.ticks_per_second <= cfg_data;
        REG_RESPONSE_LIMIT: cfg.response_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/rtc_step.sv
// Trial state and the single-pass update applied to each item.
module rtc_step #(
  parameter int unsigned LED_COUNT = rtc_pkg::DefLedCount
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           kind,
  input  logic [7:0]           delay_seconds,
  input  logic                 button,
  input  rtc_pkg::cfg_t        cfg,
  output rtc_pkg::result_t     result
);
  import rtc_pkg::*;

  localparam int unsigned LedW = (LED_COUNT > LedOutW) ? LED_COUNT : LedOutW;

  phase_t                 phase, phase_next;
  logic [CfgWidth-1:0]    idle_ticks, idle_ticks_next;
  logic [LED_COUNT-1:0]   idle_pattern, idle_pattern_next;
  logic [DelayWidth-1:0]  delay_ticks, delay_ticks_next;
  logic [DelayWidth-1:0]  delay_target, delay_target_next;
  logic [TickWidth-1:0]   reaction_ticks, reaction_ticks_next;
  logic [LED_COUNT-1:0]   led_register, led_register_next;
  logic                   written;

  logic [LED_COUNT-1:0]   pattern_now;
  logic [DelayWidth-1:0]  delay_inc;
  logic [TickWidth-1:0]   reaction_inc;
  logic [DelayWidth-1:0]  product;
  logic [LedW-1:0]        led_ext;

  // A cleared pattern restarts from the first LED.
  assign pattern_now  = (idle_pattern == '0) ? LED_COUNT'(1) : idle_pattern;
  assign delay_inc    = (delay_ticks != '1) ? DelayWidth'(delay_ticks + 1'b1) : delay_ticks;
  assign reaction_inc = (reaction_ticks != '1) ? TickWidth'(reaction_ticks + 1'b1)
                                                : reaction_ticks;
  assign product      = DelayWidth'(delay_seconds) * DelayWidth'(cfg.ticks_per_second);

  always_comb begin
    phase_next          = phase;
    idle_ticks_next     = idle_ticks;
    idle_pattern_next   = idle_pattern;
    delay_ticks_next    = delay_ticks;
    delay_target_next   = delay_target;
    reaction_ticks_next = reaction_ticks;
    led_register_next   = led_register;
    written             = 1'b0;
    case (kind)
      KIND_TICK: begin
        case (phase)
          PH_IDLE: begin
            if (idle_ticks >= cfg.idle_period) begin
              idle_ticks_next   = '0;
              led_register_next = pattern_now;
              written           = 1'b1;
              idle_pattern_next = pattern_now << 1;
            end else begin
              idle_ticks_next = CfgWidth'(idle_ticks + 1'b1);
            end
          end
          PH_ARMED: begin
            reaction_ticks_next = '0;
            delay_ticks_next    = '0;
            led_register_next   = '0;
            written             = 1'b1;
            phase_next          = PH_WAIT;
          end
          PH_WAIT: begin
            delay_ticks_next = delay_inc;
            if (delay_inc >= delay_target) begin
              led_register_next = '1;
              written           = 1'b1;
              phase_next        = PH_RUN;
            end else if (button) begin
              phase_next = PH_ERROR;
            end
          end
          PH_RUN: begin
            reaction_ticks_next = reaction_inc;
            if (button) begin
              phase_next        = PH_DONE;
              led_register_next = '0;
              written           = 1'b1;
            end else if (reaction_inc >= cfg.response_limit) begin
              phase_next        = PH_TIMEOUT;
              led_register_next = '0;
              written           = 1'b1;
            end
          end
          PH_TIMEOUT, PH_ERROR: begin
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      KIND_START: begin
        if (phase == PH_IDLE || phase == PH_DONE) begin
          delay_target_next = product;
          phase_next        = PH_ARMED;
        end
      end
      KIND_ACK: begin
        if (phase == PH_TIMEOUT || phase == PH_ERROR) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      idle_ticks     <= '0;
      idle_pattern   <= '0;
      delay_ticks    <= '0;
      delay_target   <= '0;
      reaction_ticks <= '0;
      led_register   <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      idle_ticks     <= idle_ticks_next;
      idle_pattern   <= idle_pattern_next;
      delay_ticks    <= delay_ticks_next;
      delay_target   <= delay_target_next;
      reaction_ticks <= reaction_ticks_next;
      led_register   <= led_register_next;
    end
  end

  assign led_ext               = LedW'(led_register_next);
  assign result.led_value      = led_ext[LedOutW-1:0];
  assign result.led_written    = written;
  assign result.phase_code     = phase_next;
  assign result.response_ticks = reaction_ticks_next;

endmodule

FILE: src/reaction_timer_controller_unit.sv
// Top level of the reaction timer controller: input and result registers around the step logic.
//
// Items arrive on a valid/ready input channel: a tick (with the button level),
// a start (with the pre-delay in seconds) or an acknowledge. Every accepted
// item yields exactly one result beat on the valid/ready output channel with
// the LED pattern, whether the LEDs were written, the phase and the response
// tick count as they stand after that item.
// An accepted item is held in an input register; whenever the result register
// is free to load, the step logic updates the trial state from it and loads the
// result register with the new result. One item is taken per cycle for as long
// as the result register drains every cycle; the pre-delay product is the
// longest path, one 8 by 16 bit multiply.
// When the receiver stalls, the result register holds its beat, the input
// register fills behind it and ready falls until the result is taken.
// Reset clears both stages, the trial state and sets the configuration
// registers to their defaults. The user must write configuration on the plain
// write port only while no item is in flight; the block does not enforce this.
module reaction_timer_controller_unit #(
  parameter int unsigned LED_COUNT = rtc_pkg::DefLedCount
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [rtc_pkg::CfgWidth-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    delay_seconds,
  input  logic                          button,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtc_pkg::LedOutW-1:0]   led_value,
  output logic                          led_written,
  output logic [2:0]                    phase_code,
  output logic [rtc_pkg::TickWidth-1:0] response_ticks
);
  import rtc_pkg::*;

  cfg_t       cfg;
  result_t    result;
  result_t    out_data;
  logic       hold_valid;
  logic [1:0] hold_kind;
  logic [7:0] hold_secs;
  logic       hold_button;
  logic       fire;

  // The held item is processed whenever the result register is free to load.
  assign fire     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || fire;

  rtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtc_step #(
    .LED_COUNT (LED_COUNT)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .kind          (hold_kind),
    .delay_seconds (hold_secs),
    .button        (hold_button),
    .cfg           (cfg),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      hold_kind   <= kind;
      hold_secs   <= delay_seconds;
      hold_button <= button;
    end
    if (fire) begin
      out_data <= result;
    end
  end

  assign led_value      = out_data.led_value;
  assign led_written    = out_data.led_written;
  assign phase_code     = out_data.phase_code;
  assign response_ticks = out_data.response_ticks;

endmodule

FILE: src/rtc_checker.sv
// Port-level checks for the reaction timer controller, bound to the top level.
module rtc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rtc_pkg::LedOutW-1:0]   led_value,
  input logic                          led_written,
  input logic [2:0]                    phase_code,
  input logic [rtc_pkg::TickWidth-1:0] response_ticks
);
  import rtc_pkg::*;

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_value) && $stable(led_written)
      && $stable(phase_code) && $stable(response_ticks))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // Only a start item enters the armed phase, and it never writes the LEDs.
  a_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_code == PH_ARMED |-> !led_written)
    else $error("armed result reports an LED write");

  // Entering the wait phase always clears the LEDs.
  a_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_code == PH_WAIT && led_written |-> led_value == '0)
    else $error("wait phase LED write not zero");

endmodule

bind reaction_timer_controller_unit rtc_checker u_rtc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .led_value      (led_value),
  .led_written    (led_written),
  .phase_code     (phase_code),
  .response_ticks (response_ticks)
);
